/* src/vgs_pkg.sv */
package vgs_pkg;

   // Field widths.
   localparam int SAMPLE_W = 32;
   localparam int GAIN_W   = 17;
   localparam int INDEX_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Volume writes clamp to the last entry of this range.
   localparam int TABLE_ENTRIES = 100;
   localparam int PRESET_COUNT  = 100;

   // Gain codes with special meaning.
   localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h0ffff;
   localparam logic [GAIN_W-1:0] ZERO_GAIN  = 17'h00000;

   // Reset values of the registers.
   localparam logic [INDEX_W-1:0] VOLUME_RESET  = 7'd79;
   localparam logic [INDEX_W-1:0] ZERO_DB_RESET = 7'd79;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_INDEX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_DB_INDEX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MODE    = 2'd2;

   // Saturation limits.
   localparam logic signed [32:0] SAT32_MAX = 33'sh0_7fff_ffff;
   localparam logic signed [32:0] SAT32_MIN = -33'sh1_0000_0000 + 33'sh0_8000_0000;

   // What the datapath does with a sample.
   typedef enum logic [1:0] {
      OP_ZERO,
      OP_PASS,
      OP_SCALE
   } gain_op_type;

   // Control decoded from the registers, passed to the datapath.
   typedef struct packed {
      gain_op_type       op;
      logic [GAIN_W-1:0] gain;
      logic              wide;
   } vgs_ctrl_type;

   // Preset dB gain table in unsigned 1.16 fixed point.
   localparam logic [GAIN_W-1:0] PRESET_GAINS [PRESET_COUNT] = '{
      17'h01027, 17'h010b9, 17'h01151, 17'h011ef, 17'h01292, 17'h0133b, 17'h013e9, 17'h0149e,
      17'h0155a, 17'h0161c, 17'h016e5, 17'h017b5, 17'h0188c, 17'h0196c, 17'h01a53, 17'h01b42,
      17'h01c3a, 17'h01d3a, 17'h01e44, 17'h01f57, 17'h02074, 17'h0219b, 17'h022cc, 17'h02408,
      17'h02550, 17'h026a3, 17'h02802, 17'h0296e, 17'h02ae7, 17'h02c6c, 17'h02e00, 17'h02fa2,
      17'h03153, 17'h03314, 17'h034e4, 17'h036c5, 17'h038b6, 17'h03aba, 17'h03cd0, 17'h03ef8,
      17'h04135, 17'h04385, 17'h045eb, 17'h04867, 17'h04af9, 17'h04da2, 17'h05064, 17'h0533e,
      17'h05633, 17'h05942, 17'h05c6e, 17'h05fb6, 17'h0631c, 17'h066a1, 17'h06a45, 17'h06e0b,
      17'h071f3, 17'h075ff, 17'h07a30, 17'h07e86, 17'h08304, 17'h087ab, 17'h08c7c, 17'h09179,
      17'h096a3, 17'h09bfc, 17'h0a186, 17'h0a742, 17'h0ad32, 17'h0b358, 17'h0b9b6, 17'h0c04e,
      17'h0c722, 17'h0ce34, 17'h0d586, 17'h0dd1b, 17'h0e4f5, 17'h0ed16, 17'h0f580, 17'h0ffff,
      17'h1073e, 17'h11097, 17'h11a45, 17'h1244a, 17'h12eab, 17'h1396a, 17'h1448a, 17'h15010,
      17'h15bfe, 17'h16859, 17'h17524, 17'h18264, 17'h1901c, 17'h19e50, 17'h1ad06, 17'h1bc41,
      17'h1cc07, 17'h1dc5c, 17'h1ed46, 17'h1fec9
   };

   // Table read; an index past the preset entries gives a zero gain.
   function automatic logic [GAIN_W-1:0] gain_lookup(input logic [INDEX_W-1:0] idx);
      logic [GAIN_W-1:0] g;
      g = ZERO_GAIN;
      if (int'(idx) < PRESET_COUNT) begin
         g = PRESET_GAINS[idx];
      end
      return g;
   endfunction

endpackage

/* src/vgs_csr.sv */
module vgs_csr
   import vgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output vgs_ctrl_type          ctrl
);

   logic [INDEX_W-1:0] volume_ff, volume_in;
   logic [INDEX_W-1:0] zero_db_ff, zero_db_in;
   logic               wide_ff, wide_in;
   logic [INDEX_W-1:0] volume_clamped;
   logic [GAIN_W-1:0]  gain;

   // A volume write above the table range is stored as the last entry.
   always_comb begin
      volume_clamped = csr_wdata[INDEX_W-1:0];
      if (int'(csr_wdata[INDEX_W-1:0]) > TABLE_ENTRIES - 1) begin
         volume_clamped = INDEX_W'(TABLE_ENTRIES - 1);
      end
   end

   // Register write decode; unknown indexes are ignored.
   always_comb begin
      volume_in  = volume_ff;
      zero_db_in = zero_db_ff;
      wide_in    = wide_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VOLUME_INDEX:  volume_in  = volume_clamped;
            CSR_ZERO_DB_INDEX: zero_db_in = csr_wdata[INDEX_W-1:0];
            CSR_WIDTH_MODE:    wide_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff  <= VOLUME_RESET;
         zero_db_ff <= ZERO_DB_RESET;
         wide_ff    <= 1'b0;
      end else begin
         volume_ff  <= volume_in;
         zero_db_ff <= zero_db_in;
         wide_ff    <= wide_in;
      end
   end

   // Mute wins over unity, unity over the table value.
   always_comb begin
      gain      = gain_lookup(volume_ff);
      ctrl.gain = gain;
      ctrl.wide = wide_ff;
      if (volume_ff == '0) begin
         ctrl.op = OP_ZERO;
      end else if (volume_ff == zero_db_ff) begin
         ctrl.op = OP_PASS;
      end else if (gain == ZERO_GAIN) begin
         ctrl.op = OP_ZERO;
      end else if (gain == UNITY_GAIN) begin
         ctrl.op = OP_PASS;
      end else begin
         ctrl.op = OP_SCALE;
      end
   end

endmodule

/* src/vgs_scale.sv */
module vgs_scale
   import vgs_pkg::*;
(
   input  vgs_ctrl_type                ctrl,
   input  logic signed [SAMPLE_W-1:0]  sample,
   output logic signed [SAMPLE_W-1:0]  result
);

   logic signed [SAMPLE_W-1:0] x;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [49:0]         prod;
   logic signed [32:0]         q;
   logic signed [SAMPLE_W-1:0] sat;

   // In 16-bit mode only the low half of the sample counts.
   assign x = ctrl.wide ? sample : {{16{sample[15]}}, sample[15:0]};

   // Signed product; the arithmetic shift by 16 floors toward minus infinity.
   assign gain_s = $signed({1'b0, ctrl.gain});
   assign prod   = x * gain_s;
   assign q      = prod[48:16];

   // Saturate to the selected sample width.
   always_comb begin
      if (ctrl.wide) begin
         if (q > SAT32_MAX) begin
            sat = 32'sh7fff_ffff;
         end else if (q < SAT32_MIN) begin
            sat = 32'sh8000_0000;
         end else begin
            sat = q[31:0];
         end
      end else begin
         if (q[32:15] == '0 || q[32:15] == '1) begin
            sat = {{16{q[15]}}, q[15:0]};
         end else if (q[32]) begin
            sat = 32'shffff_8000;
         end else begin
            sat = 32'sh0000_7fff;
         end
      end
   end

   always_comb begin
      case (ctrl.op)
         OP_PASS:  result = x;
         OP_SCALE: result = sat;
         default:  result = '0;
      endcase
   end

endmodule

/* src/audio_volume_gain_scaler.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_sample_in, req_last_in
// rsp       out        rsp_valid/rsp_stall   rsp_sample_out, rsp_last_out
// csr       in         csr_we                csr_index, csr_wdata
//
// One sample per cycle while rsp_stall is low; a sample passes the input register, then the result register, to rsp.
// The path from input register to result register holds one 32x18 multiply
// and the saturation compare.
// Reset clears both stage valids and loads the register defaults.
// rsp_stall backs up into req_stall only when both stages hold a sample.
module audio_volume_gain_scaler
   import vgs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic                        rsp_last_out,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   vgs_ctrl_type ctrl;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_last_ff;
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [SAMPLE_W-1:0] s2_sample_ff;
   logic                       s2_last_ff;
   logic signed [SAMPLE_W-1:0] scaled;
   logic                       s1_take;
   logic                       s2_load;

   vgs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl)
   );

   vgs_scale u_scale (
      .ctrl   (ctrl),
      .sample (s1_sample_ff),
      .result (scaled)
   );

   // The result stage loads when it is empty or its sample transfers out.
   assign s2_load   = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_take   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_take || (s1_valid_ff && !s2_load);
      s2_valid_in = s2_load || (s2_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_sample_ff <= req_sample_in;
         s1_last_ff   <= req_last_in;
      end
      if (s2_load) begin
         s2_sample_ff <= scaled;
         s2_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_sample_out = s2_sample_ff;
   assign rsp_last_out   = s2_last_ff;

endmodule

/* src/vgs_checker.sv */
module vgs_checker
   import vgs_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   input logic                        rsp_last_out,
   input logic                        csr_we,
   input logic [CSR_IDX_W-1:0]        csr_index,
   input logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic mute_ff, mute_in;
   logic wide_ff, wide_in;

   // Mirror of the mute and width settings seen on the configuration port.
   always_comb begin
      mute_in = mute_ff;
      wide_in = wide_ff;
      if (csr_we && csr_index == CSR_VOLUME_INDEX) begin
         mute_in = (csr_wdata[INDEX_W-1:0] == '0);
      end
      if (csr_we && csr_index == CSR_WIDTH_MODE) begin
         wide_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= 1'b0;
         wide_ff <= 1'b0;
      end else begin
         mute_ff <= mute_in;
         wide_ff <= wide_in;
      end
   end

   // Both stages are empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // A transfer in reaches the output through the input and result registers if the output moves.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted sample did not reach the output");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_last_out))
      else $error("stalled result changed");

   // In 16-bit mode the result is a sign-extended 16-bit value.
   a_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !wide_ff |-> rsp_sample_out[31:15] == '0
         || rsp_sample_out[31:15] == '1)
      else $error("16-bit result out of range");

   // Mute gives zero.
   a_mute: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mute_ff |-> rsp_sample_out == '0)
      else $error("muted result not zero");

endmodule

bind audio_volume_gain_scaler vgs_checker u_vgs_checker (.*);
